[rtl/core/pcx_rle_pkg.sv]
package pcx_rle_pkg;

   // sizing
   localparam int MAX_LINE_BYTES  = 4096;
   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDR_W          = $clog2(MAX_LINE_BYTES);
   localparam int POS_W           = ADDR_W + 1;
   localparam int PAL_W           = $clog2(PALETTE_ENTRIES);
   localparam int PLANE_CAP_1     = MAX_LINE_BYTES;
   localparam int PLANE_CAP_3     = MAX_LINE_BYTES / 3;

   // field widths
   localparam int REQ_W      = 2;
   localparam int BYTE_W     = 8;
   localparam int X_W        = 15;
   localparam int RUN_W      = 6;
   localparam int MODE_W     = 2;
   localparam int BPL_W      = 13;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 13;
   localparam int COLOR_W    = 3 * BYTE_W;

   localparam logic [BYTE_W-1:0] RUN_MARK = 8'hc0;
   localparam logic [BYTE_W-1:0] WHITE    = 8'hff;

   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_MODE     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BYTES_PER_LINE = 8'd1;

   typedef enum logic [REQ_W-1:0] {
      REQ_PALETTE = 2'd0,
      REQ_BYTE    = 2'd1,
      REQ_READ    = 2'd2
   } req_kind_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_MONO  = 2'd0,
      MODE_PAL4  = 2'd1,
      MODE_PAL8  = 2'd2,
      MODE_RGB24 = 2'd3
   } pixel_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_RUN = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RUN,
      S_RD_LINE,
      S_RD_G,
      S_RD_B,
      S_RD_PAL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       load;
      logic       exec;
      logic       run_step;
      logic [1:0] rd_plane;
      logic       cap_line;
      logic       cap_green;
      logic       cap_blue;
      logic       cap_pal;
   } dp_cmd_type;

   typedef struct packed {
      req_kind_type   req_kind;
      pixel_mode_type mode;
      logic           run_pending;
      logic           run_last;
      logic           range_err;
   } dp_stat_type;

endpackage

[rtl/core/pcx_rle_if.sv]
interface pcx_rle_req_if;
   logic                             valid;
   logic                             ready;
   logic [pcx_rle_pkg::REQ_W-1:0]    req_type;
   logic [pcx_rle_pkg::BYTE_W-1:0]   palette_index;
   logic [pcx_rle_pkg::BYTE_W-1:0]   palette_red;
   logic [pcx_rle_pkg::BYTE_W-1:0]   palette_green;
   logic [pcx_rle_pkg::BYTE_W-1:0]   palette_blue;
   logic [pcx_rle_pkg::BYTE_W-1:0]   data_byte;
   logic [pcx_rle_pkg::X_W-1:0]      pixel_x;

   modport source (output valid, req_type, palette_index, palette_red, palette_green,
                   palette_blue, data_byte, pixel_x, input ready);
   modport sink   (input valid, req_type, palette_index, palette_red, palette_green,
                   palette_blue, data_byte, pixel_x, output ready);
endinterface

interface pcx_rle_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pcx_rle_pkg::STATUS_W-1:0]  status;
   logic                              line_done;
   logic [pcx_rle_pkg::BYTE_W-1:0]    blue;
   logic [pcx_rle_pkg::BYTE_W-1:0]    green;
   logic [pcx_rle_pkg::BYTE_W-1:0]    red;

   modport source (output valid, status, line_done, blue, green, red, input ready);
   modport sink   (input valid, status, line_done, blue, green, red, output ready);
endinterface

interface pcx_rle_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pcx_rle_pkg::CSR_IDX_W-1:0]   index;
   logic [pcx_rle_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/pcx_rle_ctrl.sv]
module pcx_rle_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  pcx_rle_pkg::dp_stat_type stat,
   output pcx_rle_pkg::dp_cmd_type  cmd
);

   pcx_rle_pkg::state_type state_ff;
   pcx_rle_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcx_rle_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcx_rle_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = pcx_rle_pkg::S_EXEC;
            end
         end
         pcx_rle_pkg::S_EXEC: begin
            state_in = pcx_rle_pkg::S_RESP;
            if (stat.req_kind == pcx_rle_pkg::REQ_BYTE && stat.run_pending) begin
               state_in = pcx_rle_pkg::S_RUN;
            end else if (stat.req_kind == pcx_rle_pkg::REQ_READ && !stat.range_err) begin
               state_in = pcx_rle_pkg::S_RD_LINE;
            end
         end
         pcx_rle_pkg::S_RUN: begin
            if (stat.run_last) begin
               state_in = pcx_rle_pkg::S_RESP;
            end
         end
         pcx_rle_pkg::S_RD_LINE: begin
            case (stat.mode)
               pcx_rle_pkg::MODE_MONO:  state_in = pcx_rle_pkg::S_RESP;
               pcx_rle_pkg::MODE_RGB24: state_in = pcx_rle_pkg::S_RD_G;
               default:                 state_in = pcx_rle_pkg::S_RD_PAL;
            endcase
         end
         pcx_rle_pkg::S_RD_G:   state_in = pcx_rle_pkg::S_RD_B;
         pcx_rle_pkg::S_RD_B:   state_in = pcx_rle_pkg::S_RESP;
         pcx_rle_pkg::S_RD_PAL: state_in = pcx_rle_pkg::S_RESP;
         pcx_rle_pkg::S_RESP: begin
            if (rsp_ready) begin
               state_in = req_valid ? pcx_rle_pkg::S_EXEC : pcx_rle_pkg::S_IDLE;
            end
         end
         default: state_in = pcx_rle_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         pcx_rle_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pcx_rle_pkg::S_EXEC: begin
            cmd.exec     = 1'b1;
            cmd.rd_plane = 2'd0;
         end
         pcx_rle_pkg::S_RUN: begin
            cmd.run_step = 1'b1;
         end
         pcx_rle_pkg::S_RD_LINE: begin
            cmd.cap_line = 1'b1;
            cmd.rd_plane = 2'd1;
         end
         pcx_rle_pkg::S_RD_G: begin
            cmd.cap_green = 1'b1;
            cmd.rd_plane  = 2'd2;
         end
         pcx_rle_pkg::S_RD_B: begin
            cmd.cap_blue = 1'b1;
         end
         pcx_rle_pkg::S_RD_PAL: begin
            cmd.cap_pal = 1'b1;
         end
         pcx_rle_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            cmd.load  = rsp_ready && req_valid;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/core/pcx_rle_dp.sv]
module pcx_rle_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pcx_rle_pkg::dp_cmd_type               cmd,
   output pcx_rle_pkg::dp_stat_type              stat,
   // request payload
   input  logic [pcx_rle_pkg::REQ_W-1:0]         req_type,
   input  logic [pcx_rle_pkg::BYTE_W-1:0]        palette_index,
   input  logic [pcx_rle_pkg::BYTE_W-1:0]        palette_red,
   input  logic [pcx_rle_pkg::BYTE_W-1:0]        palette_green,
   input  logic [pcx_rle_pkg::BYTE_W-1:0]        palette_blue,
   input  logic [pcx_rle_pkg::BYTE_W-1:0]        data_byte,
   input  logic [pcx_rle_pkg::X_W-1:0]           pixel_x,
   // register writes
   input  logic                                  csr_we,
   input  logic [pcx_rle_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcx_rle_pkg::CSR_DATA_W-1:0]    csr_data,
   // result
   output logic [pcx_rle_pkg::STATUS_W-1:0]      status,
   output logic                                  line_done,
   output logic [pcx_rle_pkg::BYTE_W-1:0]        blue,
   output logic [pcx_rle_pkg::BYTE_W-1:0]        green,
   output logic [pcx_rle_pkg::BYTE_W-1:0]        red
);

   localparam int ADDR_W = pcx_rle_pkg::ADDR_W;
   localparam int POS_W  = pcx_rle_pkg::POS_W;
   localparam int PAL_W  = pcx_rle_pkg::PAL_W;
   localparam int BYTE_W = pcx_rle_pkg::BYTE_W;
   localparam int X_W    = pcx_rle_pkg::X_W;
   localparam int RUN_W  = pcx_rle_pkg::RUN_W;
   localparam int BPL_W  = pcx_rle_pkg::BPL_W;

   logic [BYTE_W-1:0]                line_mem [pcx_rle_pkg::MAX_LINE_BYTES];
   logic [pcx_rle_pkg::COLOR_W-1:0]  pal_mem  [pcx_rle_pkg::PALETTE_ENTRIES];

   // line and run state
   logic [POS_W-1:0]            pos_ff, pos_in;
   logic                        pend_ff, pend_in;
   logic [RUN_W-1:0]            rlen_ff, rlen_in;
   pcx_rle_pkg::pixel_mode_type mode_ff, mode_in;
   logic [BPL_W-1:0]            bpl_ff, bpl_in;

   // latched request
   pcx_rle_pkg::req_kind_type   kind_ff, kind_in;
   logic [BYTE_W-1:0]           pidx_ff, pidx_in;
   logic [BYTE_W-1:0]           pred_ff, pred_in;
   logic [BYTE_W-1:0]           pgrn_ff, pgrn_in;
   logic [BYTE_W-1:0]           pblu_ff, pblu_in;
   logic [BYTE_W-1:0]           byte_ff, byte_in;
   logic [X_W-1:0]              x_ff, x_in;

   // result
   pcx_rle_pkg::status_type     status_ff, status_in;
   logic                        done_ff, done_in;
   logic [BYTE_W-1:0]           red_ff, red_in;
   logic [BYTE_W-1:0]           green_ff, green_in;
   logic [BYTE_W-1:0]           blue_ff, blue_in;

   // memory read data
   logic [BYTE_W-1:0]               line_rd_ff;
   logic [pcx_rle_pkg::COLOR_W-1:0] pal_rd_ff;
   logic                            pal_ok_ff;

   logic                        ls_we;
   logic [ADDR_W-1:0]           ls_waddr;
   logic [ADDR_W-1:0]           ls_raddr;
   logic                        pal_we;
   logic [BYTE_W-1:0]           pal_idx;
   logic                        pal_ok;

   logic [POS_W-1:0]            plane_size;
   logic [POS_W-1:0]            line_len;
   logic [POS_W:0]              plane_off;
   logic [X_W-1:0]              byte_at;
   logic                        range_err;
   logic [POS_W-1:0]            pos_inc;
   logic [POS_W-1:0]            pos_run;
   logic [RUN_W-1:0]            run_cnt;
   logic                        is_run_byte;

   // line geometry from the registers
   always_comb begin
      int cap;
      cap = (mode_ff == pcx_rle_pkg::MODE_RGB24) ? pcx_rle_pkg::PLANE_CAP_3
                                                 : pcx_rle_pkg::PLANE_CAP_1;
      if (bpl_ff == '0) begin
         plane_size = POS_W'(1);
      end else if (int'(bpl_ff) > cap) begin
         plane_size = POS_W'(cap);
      end else begin
         plane_size = POS_W'(bpl_ff);
      end
      if (mode_ff == pcx_rle_pkg::MODE_RGB24) begin
         line_len = POS_W'({2'b00, plane_size} + {1'b0, plane_size, 1'b0});
      end else begin
         line_len = plane_size;
      end
   end

   // pixel column to byte column
   always_comb begin
      case (mode_ff)
         pcx_rle_pkg::MODE_MONO: byte_at = x_ff >> 3;
         pcx_rle_pkg::MODE_PAL4: byte_at = x_ff >> 1;
         default:                byte_at = x_ff;
      endcase
      range_err = (32'(byte_at) >= 32'(plane_size));
      case (cmd.rd_plane)
         2'd1:    plane_off = {1'b0, plane_size};
         2'd2:    plane_off = {plane_size, 1'b0};
         default: plane_off = '0;
      endcase
      ls_raddr = ADDR_W'(32'(byte_at) + 32'(plane_off));
   end

   // palette index from the fetched line byte
   always_comb begin
      if (mode_ff == pcx_rle_pkg::MODE_PAL4) begin
         pal_idx = x_ff[0] ? {4'b0000, line_rd_ff[3:0]} : {4'b0000, line_rd_ff[7:4]};
      end else begin
         pal_idx = line_rd_ff;
      end
      pal_ok = (32'(pal_idx) < pcx_rle_pkg::PALETTE_ENTRIES);
   end

   assign pos_inc     = pos_ff + POS_W'(1);
   assign run_cnt     = byte_ff[RUN_W-1:0];
   assign is_run_byte = ((byte_ff & pcx_rle_pkg::RUN_MARK) == pcx_rle_pkg::RUN_MARK);
   assign ls_waddr    = pos_ff[ADDR_W-1:0];

   always_comb begin
      pos_in    = pos_ff;
      pend_in   = pend_ff;
      rlen_in   = rlen_ff;
      mode_in   = mode_ff;
      bpl_in    = bpl_ff;
      kind_in   = kind_ff;
      pidx_in   = pidx_ff;
      pred_in   = pred_ff;
      pgrn_in   = pgrn_ff;
      pblu_in   = pblu_ff;
      byte_in   = byte_ff;
      x_in      = x_ff;
      status_in = status_ff;
      done_in   = done_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      ls_we     = 1'b0;
      pal_we    = 1'b0;
      pos_run   = pos_ff;

      if (cmd.load) begin
         kind_in   = pcx_rle_pkg::req_kind_type'(req_type);
         pidx_in   = palette_index;
         pred_in   = palette_red;
         pgrn_in   = palette_green;
         pblu_in   = palette_blue;
         byte_in   = data_byte;
         x_in      = pixel_x;
         status_in = pcx_rle_pkg::ST_OK;
         done_in   = 1'b0;
         red_in    = '0;
         green_in  = '0;
         blue_in   = '0;
      end

      if (cmd.exec) begin
         case (kind_ff)
            pcx_rle_pkg::REQ_PALETTE: begin
               pal_we = (32'(pidx_ff) < pcx_rle_pkg::PALETTE_ENTRIES);
            end
            pcx_rle_pkg::REQ_BYTE: begin
               // a pending run is filled by the sequencer instead
               if (!pend_ff) begin
                  if (is_run_byte) begin
                     if (run_cnt == '0 ||
                         ({1'b0, pos_ff} + (POS_W+1)'(run_cnt)) > {1'b0, line_len}) begin
                        status_in = pcx_rle_pkg::ST_BAD_RUN;
                        pos_in    = '0;
                        pend_in   = 1'b0;
                        rlen_in   = '0;
                     end else begin
                        pend_in = 1'b1;
                        rlen_in = run_cnt;
                     end
                  end else begin
                     ls_we = (pos_ff < line_len);
                     if (pos_inc >= line_len) begin
                        done_in = 1'b1;
                        pos_in  = '0;
                     end else begin
                        pos_in = pos_inc;
                     end
                  end
               end
            end
            pcx_rle_pkg::REQ_READ: begin
               if (range_err) begin
                  status_in = pcx_rle_pkg::ST_RANGE;
               end
            end
            default: begin
               status_in = pcx_rle_pkg::ST_OK;
            end
         endcase
      end

      if (cmd.run_step) begin
         if (pos_ff < line_len) begin
            ls_we   = 1'b1;
            pos_run = pos_inc;
         end
         rlen_in = rlen_ff - RUN_W'(1);
         if (rlen_ff == RUN_W'(1)) begin
            pend_in = 1'b0;
            rlen_in = '0;
            if (pos_run >= line_len) begin
               done_in = 1'b1;
               pos_in  = '0;
            end else begin
               pos_in = pos_run;
            end
         end else begin
            pos_in = pos_run;
         end
      end

      if (cmd.cap_line) begin
         case (mode_ff)
            pcx_rle_pkg::MODE_MONO: begin
               red_in   = line_rd_ff[3'd7 - x_ff[2:0]] ? pcx_rle_pkg::WHITE : '0;
               green_in = line_rd_ff[3'd7 - x_ff[2:0]] ? pcx_rle_pkg::WHITE : '0;
               blue_in  = line_rd_ff[3'd7 - x_ff[2:0]] ? pcx_rle_pkg::WHITE : '0;
            end
            pcx_rle_pkg::MODE_RGB24: begin
               red_in = line_rd_ff;
            end
            default: begin
               red_in = red_ff;
            end
         endcase
      end
      if (cmd.cap_green) begin
         green_in = line_rd_ff;
      end
      if (cmd.cap_blue) begin
         blue_in = line_rd_ff;
      end
      if (cmd.cap_pal && pal_ok_ff) begin
         red_in   = pal_rd_ff[23:16];
         green_in = pal_rd_ff[15:8];
         blue_in  = pal_rd_ff[7:0];
      end

      // a write to either defined register restarts the line
      if (csr_we) begin
         case (csr_index)
            pcx_rle_pkg::REG_PIXEL_MODE: begin
               mode_in = pcx_rle_pkg::pixel_mode_type'(csr_data[1:0]);
               pos_in  = '0;
               pend_in = 1'b0;
               rlen_in = '0;
            end
            pcx_rle_pkg::REG_BYTES_PER_LINE: begin
               bpl_in  = csr_data[BPL_W-1:0];
               pos_in  = '0;
               pend_in = 1'b0;
               rlen_in = '0;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         pend_ff <= 1'b0;
         rlen_ff <= '0;
         mode_ff <= pcx_rle_pkg::MODE_MONO;
         bpl_ff  <= BPL_W'(2);
      end else begin
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
         rlen_ff <= rlen_in;
         mode_ff <= mode_in;
         bpl_ff  <= bpl_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      pidx_ff   <= pidx_in;
      pred_ff   <= pred_in;
      pgrn_ff   <= pgrn_in;
      pblu_ff   <= pblu_in;
      byte_ff   <= byte_in;
      x_ff      <= x_in;
      status_ff <= status_in;
      done_ff   <= done_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      pal_ok_ff <= pal_ok;
   end

   // line store
   always_ff @(posedge clock) begin
      if (ls_we) begin
         line_mem[ls_waddr] <= byte_ff;
      end
      line_rd_ff <= line_mem[ls_raddr];
   end

   // color table
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pidx_ff[PAL_W-1:0]] <= {pred_ff, pgrn_ff, pblu_ff};
      end
      pal_rd_ff <= pal_mem[pal_idx[PAL_W-1:0]];
   end

   assign stat.req_kind    = kind_ff;
   assign stat.mode        = mode_ff;
   assign stat.run_pending = pend_ff;
   assign stat.run_last    = (rlen_ff == RUN_W'(1));
   assign stat.range_err   = range_err;

   assign status    = status_ff;
   assign line_done = done_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

endmodule

[rtl/core/pcx_rle_scanline_decoder_top.sv]
// PCX run-length scanline decoder. Each request item gives exactly one response
// item. A palette write stores one color table entry; a data byte is decoded into
// the line store (a byte with top bits 11 opens a run of its low six bits that the
// next byte fills); a pixel read converts one column of the stored line to red,
// green and blue by pixel_mode (0 mono, 1 4-bit palette, 2 8-bit palette, 3 three
// planes). Items are handled one at a time. Palette writes, literal and run-control
// bytes, reads out of range and unknown requests go from execution straight to the
// response; a run fill byte first writes the run, one line store write per cycle
// through its single write port; a mono read does one line store read, a palette
// read a line store read, then a color table read, and a three-plane read one line
// store read per plane. A new item is taken in the same cycle the response is
// taken. Register writes (csr_chan, always ready) must be made only while no item
// is in flight; a write to either defined register restarts the line at column 0,
// a write to any other index does nothing. The line store and color table are not
// cleared at reset: read only what has been written.
module pcx_rle_scanline_decoder_top (
   input  logic          clock,
   input  logic          reset,
   pcx_rle_req_if.sink   req_chan,
   pcx_rle_rsp_if.source rsp_chan,
   pcx_rle_csr_if.sink   csr_chan
);

   pcx_rle_pkg::dp_cmd_type  cmd;
   pcx_rle_pkg::dp_stat_type stat;

   // register port never stalls
   assign csr_chan.ready = 1'b1;

   // sequencer: accepts items, steps runs and multi-read pixel fetches
   pcx_rle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // memories, line position, registers and the response register
   pcx_rle_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_type      (req_chan.req_type),
      .palette_index (req_chan.palette_index),
      .palette_red   (req_chan.palette_red),
      .palette_green (req_chan.palette_green),
      .palette_blue  (req_chan.palette_blue),
      .data_byte     (req_chan.data_byte),
      .pixel_x       (req_chan.pixel_x),
      .csr_we        (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .status        (rsp_chan.status),
      .line_done     (rsp_chan.line_done),
      .blue          (rsp_chan.blue),
      .green         (rsp_chan.green),
      .red           (rsp_chan.red)
   );

endmodule
